// ===== rtl/assert_macros.svh =====
// assertion macros shared by the envelope follower rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising edge of clk, switched off while rst is high
`define APRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// implication form, same clocking and reset
`define APRE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/apre_pkg.sv =====
// shared types, constants and helpers of the peak and rms envelope follower
`default_nettype none

package apre_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int NUM_CH           = 4;
  localparam int DECAY_W          = 24;
  localparam int LEVEL_W          = 24;
  localparam int PFLOOR_W         = 24;
  localparam int RFLOOR_W         = 47;
  localparam int NCH_W            = 3;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 47;

  localparam logic [NCH_W-1:0]    ACTIVE_CH_RST  = 3'd2;
  localparam logic [DECAY_W-1:0]  PEAK_DECAY_RST = 24'd16776517;
  localparam logic [DECAY_W-1:0]  RMS_DECAY_RST  = 24'd16776517;
  localparam logic [PFLOOR_W-1:0] PEAK_FLOOR_RST = 24'd8389;
  localparam logic [RFLOOR_W-1:0] RMS_FLOOR_RST  = 47'd70368744178;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_CH  = 3'd0,
    CFG_PEAK_DECAY = 3'd1,
    CFG_RMS_DECAY  = 3'd2,
    CFG_PEAK_FLOOR = 3'd3,
    CFG_RMS_FLOOR  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [NCH_W-1:0]    active_channels;
    logic [DECAY_W-1:0]  peak_decay;
    logic [DECAY_W-1:0]  rms_decay;
    logic [PFLOOR_W-1:0] peak_floor;
    logic [RFLOOR_W-1:0] rms_floor;
  } cfg_t;

  // operand pairing of the shared multiplier
  typedef enum logic [1:0] {
    MUL_SQR  = 2'd0,
    MUL_PEAK = 2'd1,
    MUL_RLO  = 2'd2,
    MUL_RHI  = 2'd3
  } mul_op_t;

  // width of the second multiplier operand: mean or decay, whichever is wider
  function automatic int mul_b_w(input int sw);
    mul_b_w = (sw > DECAY_W) ? sw : DECAY_W;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/audio_peak_rms_envelope.sv =====
// Peak and rms envelope follower for one multichannel audio frame per item.
//
// Frame channel: frame_valid with sample_0..sample_3, taken on a rising edge
// where frame_valid is high and frame_stall is low. frame_stall stays high
// while a frame is being worked on.
// Result channel: result_valid with peak_level and rms_level, taken where
// result_valid is high and result_stall is low. The result sits in an output
// register, so the next frame is taken while the last result still waits.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no frame is in flight.
// Each frame passes through the bit-serial divide by the channel count
// (SAMPLE_WIDTH+2 steps), the square root (SAMPLE_WIDTH steps, two bits
// each) on one shared compare and subtract unit, and the shared multiplier
// and update sequence (S_SQR, S_PKM, S_RSEL, S_RLO, S_RHI, S_RACC, S_RTI);
// the next frame is taken only once the last one has left its final step.
// If the receiver stalls, a finished frame waits in its last step until the
// output register is free. Reset clears both envelopes, the output valid and
// restores the default registers.
`default_nettype none

module audio_peak_rms_envelope #(
  parameter int SAMPLE_WIDTH = apre_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               frame_valid,
  output logic                               frame_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_0,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_1,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_2,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_3,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [apre_pkg::LEVEL_W-1:0]       peak_level,
  output logic [apre_pkg::LEVEL_W-1:0]       rms_level,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [apre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apre_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import apre_pkg::*;

  `include "assert_macros.svh"

  localparam int SW    = SAMPLE_WIDTH;
  localparam int UW    = SW + 2;
  localparam int RW    = 2 * SW - 1;
  localparam int XW    = 2 * SW;
  localparam int BW    = mul_b_w(SW);
  localparam int PW    = SW + BW;
  localparam int AW    = PW + SW;
  localparam int CNT_W = $clog2(UW);
  localparam int PCW   = (SW > PFLOOR_W) ? SW : PFLOOR_W;
  localparam int RCW   = (RW > RFLOOR_W) ? RW : RFLOOR_W;

  localparam logic [SW-1:0] PEAK_MAX = {1'b1, {(SW-1){1'b0}}};
  localparam logic [RW-1:0] RMS_MAX  = {1'b1, {(RW-1){1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_DIV  = 11'b000_0000_0010,
    S_SQR  = 11'b000_0000_0100,
    S_PKM  = 11'b000_0000_1000,
    S_RSEL = 11'b000_0001_0000,
    S_RLO  = 11'b000_0010_0000,
    S_RHI  = 11'b000_0100_0000,
    S_RACC = 11'b000_1000_0000,
    S_RTI  = 11'b001_0000_0000,
    S_ROOT = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t state;

  cfg_t cfg;

  logic [CNT_W-1:0] cnt;
  logic [UW-1:0]    digits;   // dividend/quotient, later the root
  logic [UW-1:0]    rem;
  logic [NCH_W-1:0] nch;
  logic [SW-1:0]    mean;
  logic [RW-1:0]    sq;
  logic [RW-1:0]    mix;
  logic             rclr;
  logic [PW-1:0]    plo;
  logic [XW-1:0]    xr;
  logic [SW-1:0]    peak_env;
  logic [RW-1:0]    rms_env;

  logic [SW-1:0]    smp [NUM_CH];
  logic [SW-1:0]    mag [NUM_CH];
  logic [NCH_W-1:0] nclamp;
  logic [UW-1:0]    sum;

  logic             mul_en;
  mul_op_t          mul_op;
  logic [PW-1:0]    prod;

  logic [UW-1:0]    sub_lhs;
  logic [UW-1:0]    sub_rhs;
  logic             sub_ge;
  logic [UW-1:0]    sub_diff;

  logic [AW-1:0]    racc;
  logic             rms_cap;
  logic             rms_above;
  logic             peak_above;
  logic             out_load;

  logic [LEVEL_W+SW-1:0] pk_ext;
  logic [LEVEL_W+SW-1:0] rt_ext;

  apre_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  apre_mul #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mul (
    .clk        (clk),
    .en         (mul_en),
    .op         (mul_op),
    .mean       (digits[SW-1:0]),
    .peak_env   (peak_env),
    .mix        (mix),
    .peak_decay (cfg.peak_decay),
    .rms_decay  (cfg.rms_decay),
    .prod       (prod)
  );

  apre_sub #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sub (
    .lhs  (sub_lhs),
    .rhs  (sub_rhs),
    .ge   (sub_ge),
    .diff (sub_diff)
  );

  assign smp[0] = sample_0;
  assign smp[1] = sample_1;
  assign smp[2] = sample_2;
  assign smp[3] = sample_3;

  // zero channels counts as one, more than four as four
  always_comb begin
    if (cfg.active_channels == '0) begin
      nclamp = NCH_W'(1);
    end else if (cfg.active_channels > NCH_W'(NUM_CH)) begin
      nclamp = NCH_W'(NUM_CH);
    end else begin
      nclamp = cfg.active_channels;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      // most negative sample wraps to exactly 2^(SW-1), which still fits
      mag[i] = smp[i][SW-1] ? (~smp[i] + SW'(1)) : smp[i];
      if (NCH_W'(i) < nclamp) begin
        sum = sum + UW'(mag[i]);
      end
    end
  end

  // shared unit operands: one quotient bit or one root bit per cycle
  always_comb begin
    if (state == S_ROOT) begin
      sub_lhs = {rem[UW-3:0], xr[XW-1 -: 2]};
      sub_rhs = {digits[SW-1:0], 2'b01};
    end else begin
      sub_lhs = {rem[UW-2:0], digits[UW-1]};
      sub_rhs = UW'(nch);
    end
  end

  always_comb begin
    mul_en = 1'b1;
    mul_op = MUL_SQR;
    unique case (state)
      S_SQR:   mul_op = MUL_SQR;
      S_PKM:   mul_op = MUL_PEAK;
      S_RLO:   mul_op = MUL_RLO;
      S_RHI:   mul_op = MUL_RHI;
      default: mul_en = 1'b0;
    endcase
  end

  // upper partial product weighs 2^SW, then drop the 24 fraction bits
  assign racc       = {prod, {SW{1'b0}}} + AW'(plo);
  assign rms_cap    = sq > rms_env;
  assign rms_above  = RCW'(rms_env) > RCW'(cfg.rms_floor);
  assign peak_above = PCW'(peak_env) > PCW'(cfg.peak_floor);

  assign pk_ext = (LEVEL_W + SW)'(peak_env);
  assign rt_ext = (LEVEL_W + SW)'(digits[SW-1:0]);

  assign frame_stall = (state != S_IDLE);

  // the output register takes a new result once the held one has gone
  assign out_load = (state == S_DONE) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      peak_env     <= '0;
      rms_env      <= '0;
      cnt          <= '0;
    end else begin
      if (result_valid && !result_stall && !out_load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (frame_valid) begin
            digits <= sum;
            rem    <= '0;
            nch    <= nclamp;
            cnt    <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= sub_ge ? sub_diff : sub_lhs;
          digits <= {digits[UW-2:0], sub_ge};
          cnt    <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(UW - 1)) begin
            state <= S_SQR;
          end
        end
        S_SQR: begin
          mean  <= digits[SW-1:0];
          state <= S_PKM;
        end
        S_PKM: begin
          sq    <= prod[RW-1:0];
          state <= S_RSEL;
        end
        S_RSEL: begin
          // a mean equal to the state does not replace it
          if (mean > peak_env) begin
            peak_env <= mean;
          end else if (peak_above) begin
            peak_env <= prod[DECAY_W +: SW];
          end else begin
            peak_env <= '0;
          end
          mix   <= rms_cap ? sq : rms_env;
          rclr  <= !rms_cap && !rms_above;
          state <= S_RLO;
        end
        S_RLO: begin
          state <= S_RHI;
        end
        S_RHI: begin
          plo   <= prod;
          state <= S_RACC;
        end
        S_RACC: begin
          rms_env <= rclr ? '0 : racc[DECAY_W +: RW];
          state   <= S_RTI;
        end
        S_RTI: begin
          xr     <= XW'(rms_env);
          rem    <= '0;
          digits <= '0;
          cnt    <= '0;
          state  <= S_ROOT;
        end
        S_ROOT: begin
          rem    <= sub_ge ? sub_diff : sub_lhs;
          digits <= {digits[UW-2:0], sub_ge};
          xr     <= {xr[XW-3:0], 2'b00};
          cnt    <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SW - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // wait here while the previous result is still held
          if (out_load) begin
            peak_level   <= pk_ext[LEVEL_W-1:0];
            rms_level    <= rt_ext[LEVEL_W-1:0];
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `APRE_ASSERT(a_peak_range, peak_env <= PEAK_MAX, "peak envelope above full scale")
  `APRE_ASSERT(a_rms_range, rms_env <= RMS_MAX, "rms envelope above full scale")
  `APRE_ASSERT_IMP(a_div_rem, state == S_DIV, rem < UW'(nch),
                   "divider remainder not below channel count")
  `APRE_ASSERT_IMP(a_root_rem, state == S_ROOT, rem <= UW'({digits[SW-1:0], 1'b0}),
                   "square root remainder exceeds twice the root")
  `APRE_ASSERT_IMP(a_result_src, $rose(result_valid), $past(state == S_DONE),
                   "result raised outside the final step")

endmodule

`default_nettype wire

// ===== rtl/apre_cfg.sv =====
// configuration register file of the envelope follower
`default_nettype none

module apre_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [apre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apre_pkg::CFG_DATA_W-1:0]  cfg_data,
  output apre_pkg::cfg_t                   cfg
);
  import apre_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_channels <= ACTIVE_CH_RST;
      cfg.peak_decay      <= PEAK_DECAY_RST;
      cfg.rms_decay       <= RMS_DECAY_RST;
      cfg.peak_floor      <= PEAK_FLOOR_RST;
      cfg.rms_floor       <= RMS_FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ACTIVE_CH:  cfg.active_channels <= cfg_data[NCH_W-1:0];
        CFG_PEAK_DECAY: cfg.peak_decay      <= cfg_data[DECAY_W-1:0];
        CFG_RMS_DECAY:  cfg.rms_decay       <= cfg_data[DECAY_W-1:0];
        CFG_PEAK_FLOOR: cfg.peak_floor      <= cfg_data[PFLOOR_W-1:0];
        CFG_RMS_FLOOR:  cfg.rms_floor       <= cfg_data[RFLOOR_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/apre_sub.sv =====
// shared compare and subtract unit for the divider and square root steps
`default_nettype none

module apre_sub #(
  parameter int SAMPLE_WIDTH = apre_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic [SAMPLE_WIDTH+1:0] lhs,
  input  logic [SAMPLE_WIDTH+1:0] rhs,
  output logic                    ge,
  output logic [SAMPLE_WIDTH+1:0] diff
);
  import apre_pkg::*;

  localparam int W = SAMPLE_WIDTH + 2;

  logic [W:0] wide;

  // borrow out of the top bit means lhs < rhs
  assign wide = {1'b0, lhs} - {1'b0, rhs};
  assign ge   = ~wide[W];
  assign diff = wide[W-1:0];

endmodule

`default_nettype wire

// ===== rtl/apre_mul.sv =====
// shared multiplier with operand selection and registered product
`default_nettype none

module apre_mul #(
  parameter int SAMPLE_WIDTH = apre_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  apre_pkg::mul_op_t                    op,
  input  logic [SAMPLE_WIDTH-1:0]              mean,
  input  logic [SAMPLE_WIDTH-1:0]              peak_env,
  input  logic [2*SAMPLE_WIDTH-2:0]            mix,
  input  logic [apre_pkg::DECAY_W-1:0]         peak_decay,
  input  logic [apre_pkg::DECAY_W-1:0]         rms_decay,
  output logic [SAMPLE_WIDTH+apre_pkg::mul_b_w(SAMPLE_WIDTH)-1:0] prod
);
  import apre_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int BW = mul_b_w(SAMPLE_WIDTH);
  localparam int RW = 2 * SAMPLE_WIDTH - 1;
  localparam int PW = SW + BW;

  logic [SW-1:0] a;
  logic [BW-1:0] b;

  always_comb begin
    unique case (op)
      MUL_SQR: begin
        a = mean;
        b = BW'(mean);
      end
      MUL_PEAK: begin
        a = peak_env;
        b = BW'(peak_decay);
      end
      MUL_RLO: begin
        a = mix[SW-1:0];
        b = BW'(rms_decay);
      end
      MUL_RHI: begin
        // upper part of the rms operand, weight 2^SW
        a = SW'(mix[RW-1:SW]);
        b = BW'(rms_decay);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(a) * PW'(b);
    end
  end

endmodule

`default_nettype wire

// ===== tb/audio_peak_rms_envelope_tb.sv =====
// testbench for the peak and rms envelope follower: directed table, then random frames
`default_nettype none

module audio_peak_rms_envelope_tb;
  import apre_pkg::*;

  localparam int SW              = SAMPLE_WIDTH_DEF;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int TAIL_CYCLES     = 70;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_PHASES      = 6;

  localparam int MOST_NEG = -8388608;
  localparam int MOST_POS = 8388607;

  localparam logic [CFG_IDX_W-1:0]  IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0]  IDX_SPARE_HI = 3'd7;
  localparam logic [DECAY_W-1:0]    DECAY_MAX    = 24'hFFFFFF;
  localparam logic [PFLOOR_W-1:0]   LEVEL_UNITY  = 24'h800000;
  localparam logic [RFLOOR_W-1:0]   POWER_UNITY  = 47'h4000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] DATA_ONES    = '1;

  typedef logic [NUM_CH-1:0][SW-1:0] frame_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] rms;
  } levels_t;

  typedef enum logic {ROW_FRAME, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    frame_t                 f;
    logic                   typed;
    levels_t                lv;
  } dir_row_t;

  typedef enum {FS_LOUD, FS_QUIET, FS_EXTREME, FS_SILENT} frame_style_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  frame_valid = 1'b0;
  logic                  frame_stall;
  logic signed [SW-1:0]  sample_0 = '0;
  logic signed [SW-1:0]  sample_1 = '0;
  logic signed [SW-1:0]  sample_2 = '0;
  logic signed [SW-1:0]  sample_3 = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [LEVEL_W-1:0]    peak_level;
  logic [LEVEL_W-1:0]    rms_level;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // typed expectation travels with the frame payload
  logic                  typed_chk = 1'b0;
  levels_t               typed_lv = '0;

  // predictor copy of the settings and envelopes
  logic [NCH_W-1:0]      set_chans;
  logic [DECAY_W-1:0]    set_pk_decay;
  logic [DECAY_W-1:0]    set_rms_decay;
  logic [PFLOOR_W-1:0]   set_pk_floor;
  logic [RFLOOR_W-1:0]   set_rms_floor;
  logic [LEVEL_W-1:0]    env_peak;
  logic [RFLOOR_W-1:0]   env_power;

  levels_t               level_q[$];
  levels_t               want_lv;
  levels_t               new_lv;
  int                    frames_sent = 0;
  int                    results_got = 0;
  int                    mismatches = 0;
  int                    cycle_count = 0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;

  audio_peak_rms_envelope uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_level(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic [SW-1:0] magnitude(logic [SW-1:0] raw);
    return raw[SW-1] ? (~raw + 1'b1) : raw;
  endfunction

  // truncating multiply by an unsigned q0.24 fraction
  function automatic logic [RFLOOR_W-1:0] scale_q24(logic [RFLOOR_W-1:0] a,
                                                   logic [DECAY_W-1:0] d);
    logic [RFLOOR_W+DECAY_W-1:0] p;
    p = (RFLOOR_W+DECAY_W)'(a) * (RFLOOR_W+DECAY_W)'(d);
    return p[RFLOOR_W+DECAY_W-1:DECAY_W];
  endfunction

  function automatic logic [LEVEL_W-1:0] floor_sqrt(logic [RFLOOR_W-1:0] x);
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] trial;
    r = '0;
    for (int b = LEVEL_W - 1; b >= 0; b--) begin
      trial = r | (LEVEL_W'(1) << b);
      if (48'(trial) * 48'(trial) <= 48'(x)) r = trial;
    end
    return r;
  endfunction

  function automatic levels_t follow_envelope(frame_t f);
    logic [NCH_W-1:0]    n;
    logic [SW+1:0]       total;
    logic [SW+1:0]       quot;
    logic [LEVEL_W-1:0]  mean;
    logic [RFLOOR_W-1:0] sq;
    logic [RFLOOR_W-1:0] t;
    levels_t             lv;
    n = set_chans;
    if (n == '0) n = NCH_W'(1);
    else if (n > NCH_W'(NUM_CH)) n = NCH_W'(NUM_CH);
    total = '0;
    for (int i = 0; i < NUM_CH; i++)
      if (i < n) total += (SW+2)'(magnitude(f[i]));
    quot = total / (SW+2)'(n);
    mean = quot[LEVEL_W-1:0];
    if (mean > env_peak) begin
      env_peak = mean;
    end else if (env_peak > set_pk_floor) begin
      t = scale_q24(RFLOOR_W'(env_peak), set_pk_decay);
      env_peak = t[LEVEL_W-1:0];
    end else begin
      env_peak = '0;
    end
    sq = RFLOOR_W'(mean) * RFLOOR_W'(mean);
    if (sq > env_power) env_power = scale_q24(sq, set_rms_decay);
    else if (env_power > set_rms_floor) env_power = scale_q24(env_power, set_rms_decay);
    else env_power = '0;
    lv.peak = env_peak;
    lv.rms = floor_sqrt(env_power);
    return lv;
  endfunction

  function automatic void store_setting(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_ACTIVE_CH:  set_chans = d[NCH_W-1:0];
      CFG_PEAK_DECAY: set_pk_decay = d[DECAY_W-1:0];
      CFG_RMS_DECAY:  set_rms_decay = d[DECAY_W-1:0];
      CFG_PEAK_FLOOR: set_pk_floor = d[PFLOOR_W-1:0];
      CFG_RMS_FLOOR:  set_rms_floor = d[RFLOOR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic dir_row_t frame_row(int s0, int s1, int s2, int s3,
                                         logic typed = 1'b0, int pk = 0, int rm = 0);
    dir_row_t r;
    r = '0;
    r.kind = ROW_FRAME;
    r.f[0] = SW'(s0);
    r.f[1] = SW'(s1);
    r.f[2] = SW'(s2);
    r.f[3] = SW'(s3);
    r.typed = typed;
    r.lv.peak = LEVEL_W'(pk);
    r.lv.rms = LEVEL_W'(rm);
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = v;
    return r;
  endfunction

  function automatic frame_t random_frame(frame_style_t s);
    frame_t f;
    for (int i = 0; i < NUM_CH; i++) begin
      case (s)
        FS_LOUD:  f[i] = SW'($urandom);
        FS_QUIET: f[i] = SW'(int'($urandom_range(0, 512)) - 256);
        FS_EXTREME: begin
          case ($urandom_range(0, 4))
            0: f[i] = SW'(MOST_NEG);
            1: f[i] = SW'(MOST_POS);
            2: f[i] = '0;
            3: f[i] = '1;
            default: f[i] = SW'(1);
          endcase
        end
        default: f[i] = '0;
      endcase
    end
    return f;
  endfunction

  function automatic logic [DECAY_W-1:0] pick_decay();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return DECAY_MAX;
      2: return DECAY_MAX - DECAY_W'($urandom_range(0, 65535));
      3: return DECAY_W'($urandom);
      default: return DECAY_W'($urandom_range(0, 24'h800000));
    endcase
  endfunction

  function automatic logic [PFLOOR_W-1:0] pick_peak_floor();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return LEVEL_UNITY;
      2: return PFLOOR_W'($urandom_range(0, 65535));
      default: return PFLOOR_W'($urandom_range(0, LEVEL_UNITY));
    endcase
  endfunction

  function automatic logic [RFLOOR_W-1:0] pick_rms_floor();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return POWER_UNITY;
      2: return RFLOOR_W'($urandom_range(0, 32'h4000_0000));
      default: return (RFLOOR_W'($urandom_range(0, 16383)) << 32) | RFLOOR_W'($urandom);
    endcase
  endfunction

  // lower valid and hold off until every item has its result back
  task automatic settle();
    if (results_got != frames_sent) begin
      frame_valid <= 1'b0;
      while (results_got != frames_sent) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_frame(frame_t f, logic typed = 1'b0, levels_t lv = '0);
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    sample_0 <= f[0];
    sample_1 <= f[1];
    sample_2 <= f[2];
    sample_3 <= f[3];
    typed_chk <= typed;
    typed_lv <= lv;
    do @(posedge clk); while (frame_stall);
    frames_sent++;
  endtask

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      set_chans = ACTIVE_CH_RST;
      set_pk_decay = PEAK_DECAY_RST;
      set_rms_decay = RMS_DECAY_RST;
      set_pk_floor = PEAK_FLOOR_RST;
      set_rms_floor = RMS_FLOOR_RST;
      env_peak = '0;
      env_power = '0;
      level_q.delete();
    end else begin
      // results first so a frame taken on the same edge cannot mask a stray one
      if (result_valid && !result_stall) begin
        results_got++;
        if (level_q.size() == 0) begin
          flag_level("unexpected item, peak_level", peak_level, 0);
        end else begin
          want_lv = level_q.pop_front();
          if (peak_level !== want_lv.peak) flag_level("peak_level", peak_level, want_lv.peak);
          if (rms_level !== want_lv.rms) flag_level("rms_level", rms_level, want_lv.rms);
        end
      end
      if (cfg_valid && cfg_ready) store_setting(cfg_index, cfg_data);
      if (frame_valid && !frame_stall) begin
        new_lv = follow_envelope({sample_3, sample_2, sample_1, sample_0});
        level_q.push_back(typed_chk ? typed_lv : new_lv);
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    int sent;
    int pick;
    int run;
    rows = '{
      frame_row(0, 0, 0, 0, 1'b1, 0, 0),
      frame_row(MOST_NEG, MOST_NEG, 0, 0),
      frame_row(MOST_NEG, MOST_NEG, 0, 0),
      frame_row(MOST_POS, MOST_NEG, 5, 5),
      frame_row(1, -1, 0, 0),
      frame_row(0, 0, 0, 0),
      // channel count zero and above four fold to one and four
      reg_row(CFG_ACTIVE_CH, CFG_DATA_W'(0)),
      frame_row(100, MOST_NEG, MOST_POS, 5),
      reg_row(CFG_ACTIVE_CH, CFG_DATA_W'(7)),
      frame_row(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG),
      reg_row(CFG_ACTIVE_CH, CFG_DATA_W'(5)),
      frame_row(3, -4, 5, -7),
      reg_row(CFG_ACTIVE_CH, CFG_DATA_W'(3)),
      frame_row(1, 2, 2, 9),
      reg_row(CFG_ACTIVE_CH, CFG_DATA_W'(1)),
      frame_row(-1, 9, 9, 9),
      reg_row(CFG_ACTIVE_CH, CFG_DATA_W'(4)),
      // writes past the register list must change nothing
      reg_row(IDX_SPARE_HI, DATA_ONES),
      reg_row(IDX_SPARE_LO, '0),
      frame_row(MOST_NEG, MOST_POS, MOST_NEG, MOST_POS),
      // zero decays: release drops straight to zero, rms capture is always zero
      reg_row(CFG_PEAK_DECAY, '0),
      reg_row(CFG_RMS_DECAY, '0),
      frame_row(0, 0, 0, 0, 1'b1, 0, 0),
      frame_row(1000, 1000, 1000, 1000, 1'b1, 1000, 0),
      frame_row(0, 0, 0, 0, 1'b1, 0, 0),
      frame_row(20000, 20000, 20000, 20000, 1'b1, 20000, 0),
      frame_row(0, 0, 0, 0, 1'b1, 0, 0),
      reg_row(CFG_PEAK_DECAY, DECAY_MAX),
      reg_row(CFG_RMS_DECAY, DECAY_MAX),
      reg_row(CFG_PEAK_FLOOR, '0),
      reg_row(CFG_RMS_FLOOR, '0),
      frame_row(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG),
      frame_row(0, 0, 0, 0),
      frame_row(0, 0, 0, 0),
      // floors at full scale clear any state that is not overtaken
      reg_row(CFG_PEAK_FLOOR, LEVEL_UNITY),
      reg_row(CFG_RMS_FLOOR, POWER_UNITY),
      frame_row(0, 0, 0, 0, 1'b1, 0, 0),
      frame_row(MOST_POS, MOST_POS, MOST_POS, MOST_POS)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 48;
    foreach (rows[k]) begin
      if (rows[k].kind == ROW_REG) begin
        settle();
        write_reg(rows[k].idx, rows[k].data);
      end else begin
        send_frame(rows[k].f, rows[k].typed, rows[k].lv);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 48;
        recv_idle_pct = 12;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      write_reg(CFG_ACTIVE_CH, ($urandom_range(0, 3) == 0) ?
                CFG_DATA_W'($urandom_range(0, 7)) : CFG_DATA_W'($urandom_range(1, 4)));
      write_reg(CFG_PEAK_DECAY, CFG_DATA_W'(pick_decay()));
      write_reg(CFG_RMS_DECAY, CFG_DATA_W'(pick_decay()));
      write_reg(CFG_PEAK_FLOOR, CFG_DATA_W'(pick_peak_floor()));
      write_reg(CFG_RMS_FLOOR, CFG_DATA_W'(pick_rms_floor()));
      write_reg(IDX_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 49) == 0) settle();
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // attack then a release tail of quiet or silent items
          send_frame(random_frame(FS_LOUD));
          sent++;
          run = $urandom_range(0, 20);
          repeat (run) begin
            send_frame(random_frame($urandom_range(0, 1) ? FS_SILENT : FS_QUIET));
            sent++;
          end
        end else if (pick < 85) begin
          send_frame(random_frame(FS_LOUD));
          sent++;
        end else begin
          send_frame(random_frame(FS_EXTREME));
          sent++;
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (level_q.size() != 0) flag_level("items never returned", 0, level_q.size());
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/apre_pkg.sv
rtl/apre_cfg.sv
rtl/apre_sub.sv
rtl/apre_mul.sv
rtl/audio_peak_rms_envelope.sv
tb/audio_peak_rms_envelope_tb.sv
